// ===== src/ph_trimmed_window_average_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the trimmed window average block
// Clocked, reset-gated property checks that report through $error.
// ----------------------------------------------------------------------------
`ifndef PH_TRIMMED_WINDOW_AVERAGE_ASSERT_SVH
`define PH_TRIMMED_WINDOW_AVERAGE_ASSERT_SVH

// Check a property on every rising edge outside reset
`define PTW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that a trigger is followed by an expected condition in the next cycle
`define PTW_ASSERT_NEXT(label, trig, expct, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (expct)) \
        else $error(msg);

`endif

// ===== src/ptw_pkg.sv =====
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared constants, widths and types of the trimmed window average block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptw_pkg;

    // Window and sample geometry
    localparam int WINDOW  = 40;
    localparam int ADC_W   = 10;
    localparam int ADC_MAX = 1023;
    localparam int CNT_W   = $clog2(WINDOW);

    // Sum of the whole window and the largest trimmed sum
    localparam int SUM_W    = $clog2(WINDOW * ADC_MAX + 1);
    localparam int TRIM_MAX = (WINDOW - 2) * ADC_MAX;

    // Configuration registers
    localparam int SLOPE_W    = 14;
    localparam int OFFS_W     = 15;
    localparam int CFG_DATA_W = OFFS_W;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = CFG_IDX_W'(1);

    localparam logic        [SLOPE_W-1:0] SLOPE_RST  = SLOPE_W'(3500);
    localparam logic signed [OFFS_W-1:0]  OFFSET_RST = OFFS_W'(-1810);

    // Output widths
    localparam int MEAN_W = 10;
    localparam int MV_W   = 13;
    localparam int PH_W   = 17;

    // Scale constant: millivolts of the reference
    localparam logic [MV_W-1:0] REF_MV = MV_W'(5000);

    // Every output is a numerator divided by (WINDOW - 2) * ADC_MAX: the mean
    // takes trim * ADC_MAX, millivolts trim * 5000 and pH trim * slope * 5.
    // The division is a multiply by the rounded-up reciprocal, scaled by
    // 2 ** RCP_SHIFT, which is exact over the whole numerator range.
    localparam int     SL5_W     = SLOPE_W + 3;
    localparam longint NUM_MAX   = longint'(5 * (2 ** SLOPE_W - 1)) * TRIM_MAX;
    localparam int     DVD_W     = $clog2(NUM_MAX + 1);
    localparam int     RCP_SHIFT = 47;
    localparam longint RCP_VAL   = ((longint'(1) << RCP_SHIFT) + TRIM_MAX - 1) / TRIM_MAX;
    localparam int     RCP_W     = $clog2(RCP_VAL + 1);
    localparam int     PRD_W     = DVD_W + RCP_W;
    localparam int     QUO_W     = PRD_W - RCP_SHIFT;

    localparam logic [RCP_W-1:0] RCP_SCALE = RCP_W'(RCP_VAL);

    // pH sum before saturation
    localparam int PHS_W = SL5_W + 2;
    localparam logic signed [PHS_W-1:0] PH_SAT_HI = PHS_W'(2 ** (PH_W - 1) - 1);
    localparam logic signed [PHS_W-1:0] PH_SAT_LO = PHS_W'(-(2 ** (PH_W - 1)));

    // Control of the ring cells
    typedef struct packed {
        logic shift;
        logic insert;
    } t_cell_ctl;

endpackage

// ===== src/ph_trimmed_window_average.sv =====
// ----------------------------------------------------------------------------
// ph_trimmed_window_average
// Moving trimmed mean of pH probe samples, scaled to millivolts and pH.
// ----------------------------------------------------------------------------
// Each input transaction pushes one 10-bit sample into a ring of WINDOW
// entries (zero after reset), and one result follows: the window sum without
// one minimum and one maximum, divided down to counts, to millivolts on a
// 5 V reference and to pH in thousandths (slope * volts + offset, saturated
// to 17 bits). One transaction is in work at a time. From acceptance, the
// sequencer rotates the ring of cells past the sum and min/max logic
// (ST_SCAN), trims the sum (ST_TRIM), forms the three numerators (ST_MUL),
// multiplies them by the reciprocal of (WINDOW - 2) * 1023 (ST_LAUNCH)
// and loads the output register once the output is free (ST_DIV).
// The input is ready again in the cycle after the result is loaded. A new
// sample is accepted while the previous result still waits at the output;
// its own result then holds in the last stage until the output is taken.
// Configuration writes take effect at once and belong to quiet periods
// between transactions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ph_trimmed_window_average_assert.svh"

module ph_trimmed_window_average (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ptw_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ptw_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [ptw_pkg::ADC_W-1:0]           i_adc_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [ptw_pkg::MEAN_W-1:0]          o_mean_raw,
    output logic [ptw_pkg::MV_W-1:0]            o_probe_millivolts,
    output logic signed [ptw_pkg::PH_W-1:0]     o_ph_milli
);
    import ptw_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TRIM,
        ST_MUL,
        ST_LAUNCH,
        ST_DIV
    } t_state;

    t_state                    r_state;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_out_valid;
    logic [MEAN_W-1:0]         r_mean;
    logic [MV_W-1:0]           r_mv;
    logic signed [PH_W-1:0]    r_ph;

    logic [SLOPE_W-1:0]        r_slope;
    logic signed [OFFS_W-1:0]  r_offset;

    logic [SUM_W-1:0]          r_total;
    logic [ADC_W-1:0]          r_lo;
    logic [ADC_W-1:0]          r_hi;
    logic [SUM_W-1:0]          r_trim;
    logic [DVD_W-1:0]          r_num_mean;
    logic [DVD_W-1:0]          r_num_mv;
    logic [DVD_W-1:0]          r_num_ph;

    logic                      w_in_acc;
    logic                      w_out_free;
    logic                      w_publish;
    t_cell_ctl                 w_cell_ctl;
    logic [ADC_W-1:0]          w_cell_q [WINDOW];
    logic [ADC_W-1:0]          w_tail;

    logic [SL5_W-1:0]          w_slope5;
    logic [DVD_W-1:0]          w_mean_num;
    logic [SUM_W+MV_W-1:0]     w_mv_prod;
    logic [DVD_W-1:0]          w_ph_prod;

    logic                      w_div_start;
    logic                      w_done_mean;
    logic                      w_done_mv;
    logic                      w_done_ph;
    logic                      w_div_done;
    logic [QUO_W-1:0]          w_quo_mean;
    logic [QUO_W-1:0]          w_quo_mv;
    logic [QUO_W-1:0]          w_quo_ph;

    logic signed [PHS_W-1:0]   w_ph_sum;
    logic signed [PH_W-1:0]    w_ph_sat;

    // Handshake and ring control
    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_div_start = (r_state == ST_LAUNCH);
    assign w_div_done  = w_done_mean && w_done_mv && w_done_ph;
    assign w_publish   = (r_state == ST_DIV) && w_div_done && w_out_free;

    assign w_cell_ctl.shift  = w_in_acc || (r_state == ST_SCAN);
    assign w_cell_ctl.insert = w_in_acc;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slope  <= SLOPE_RST;
            r_offset <= OFFSET_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SLOPE:  r_slope  <= i_cfg_data[SLOPE_W-1:0];
                CFG_OFFSET: r_offset <= signed'(i_cfg_data[OFFS_W-1:0]);
            endcase
        end
    end

    // Ring of sample cells, rotating toward the tail
    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        ptw_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_cell_ctl),
            .i_head   (1'(g == 0)),
            .i_prev   (w_cell_q[(g + WINDOW - 1) % WINDOW]),
            .i_sample (i_adc_sample),
            .o_q      (w_cell_q[g])
        );
    end

    assign w_tail = w_cell_q[WINDOW-1];

    // Scale numerators
    assign w_slope5   = {1'b0, r_slope, 2'b00} + SL5_W'(r_slope);
    assign w_mean_num = DVD_W'(r_trim) * DVD_W'(ADC_MAX);
    assign w_mv_prod  = (SUM_W + MV_W)'(r_trim) * (SUM_W + MV_W)'(REF_MV);
    assign w_ph_prod  = DVD_W'(w_slope5) * DVD_W'(r_trim);

    // Sum, extremes, trim and numerators
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SCAN) begin
            if (r_cnt == '0) begin
                r_total <= SUM_W'(w_tail);
                r_lo    <= w_tail;
                r_hi    <= w_tail;
            end else begin
                r_total <= r_total + SUM_W'(w_tail);
                if (w_tail < r_lo) begin
                    r_lo <= w_tail;
                end
                if (w_tail > r_hi) begin
                    r_hi <= w_tail;
                end
            end
        end
        if (r_state == ST_TRIM) begin
            r_trim <= r_total - SUM_W'(r_lo) - SUM_W'(r_hi);
        end
        if (r_state == ST_MUL) begin
            r_num_mean <= w_mean_num;
            r_num_mv   <= DVD_W'(w_mv_prod);
            r_num_ph   <= w_ph_prod;
        end
    end

    // Reciprocal scaling for counts, millivolts and pH
    ptw_div u_div_mean (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_num_mean),
        .o_done     (w_done_mean),
        .o_quotient (w_quo_mean)
    );

    ptw_div u_div_mv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_num_mv),
        .o_done     (w_done_mv),
        .o_quotient (w_quo_mv)
    );

    ptw_div u_div_ph (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_num_ph),
        .o_done     (w_done_ph),
        .o_quotient (w_quo_ph)
    );

    // Add offset and clamp to the output range
    always_comb begin
        w_ph_sum = PHS_W'(signed'({1'b0, w_quo_ph[SL5_W-1:0]})) + PHS_W'(r_offset);
        priority if (w_ph_sum > PH_SAT_HI) begin
            w_ph_sat = PH_W'(PH_SAT_HI);
        end else if (w_ph_sum < PH_SAT_LO) begin
            w_ph_sat = PH_W'(PH_SAT_LO);
        end else begin
            w_ph_sat = PH_W'(w_ph_sum);
        end
    end

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_publish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_cnt   <= '0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(WINDOW - 1)) begin
                        r_state <= ST_TRIM;
                    end
                end
                ST_TRIM:   r_state <= ST_MUL;
                ST_MUL:    r_state <= ST_LAUNCH;
                ST_LAUNCH: r_state <= ST_DIV;
                ST_DIV: begin
                    if (w_publish) begin
                        r_mean  <= w_quo_mean[MEAN_W-1:0];
                        r_mv    <= w_quo_mv[MV_W-1:0];
                        r_ph    <= w_ph_sat;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_mean_raw         = r_mean;
    assign o_probe_millivolts = r_mv;
    assign o_ph_milli         = r_ph;

    // Accepted transaction starts a scan from the first cell
    `PTW_ASSERT_NEXT(a_accept_scan, w_in_acc, (r_state == ST_SCAN) && (r_cnt == '0), "scan did not start")
    // The three scaling units run in lockstep
    `PTW_ASSERT(a_div_lockstep, (w_done_mean == w_done_mv) && (w_done_mv == w_done_ph), "dividers diverged")
    // Trimmed sum never exceeds the full-scale trimmed window
    `PTW_ASSERT(a_trim_bound, (r_state == ST_MUL) |-> (r_trim <= SUM_W'(TRIM_MAX)), "trim overflow")
    // Extremes stay ordered once the scan has started
    `PTW_ASSERT(a_lo_hi, ((r_state == ST_SCAN) && (r_cnt != '0)) |-> (r_lo <= r_hi), "min above max")
    // Finished scaling with a free output publishes a result and returns to idle
    `PTW_ASSERT_NEXT(a_publish, w_publish, r_out_valid && (r_state == ST_IDLE), "result not published")

endmodule

// ===== src/ptw_cell.sv =====
// ----------------------------------------------------------------------------
// ptw_cell
// One entry of the sample ring: takes its neighbor's value on every shift,
// or the new sample when it heads the ring and a transaction is inserted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptw_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  ptw_pkg::t_cell_ctl       i_ctl,
    input  logic                     i_head,
    input  logic [ptw_pkg::ADC_W-1:0] i_prev,
    input  logic [ptw_pkg::ADC_W-1:0] i_sample,
    output logic [ptw_pkg::ADC_W-1:0] o_q
);
    import ptw_pkg::*;

    logic [ADC_W-1:0] r_q;

    // Hold, rotate or load the entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_ctl.shift) begin
            r_q <= (i_ctl.insert && i_head) ? i_sample : i_prev;
        end
    end

    assign o_q = r_q;

endmodule

// ===== src/ptw_div.sv =====
// ----------------------------------------------------------------------------
// ptw_div
// Division by (WINDOW - 2) * ADC_MAX as one registered reciprocal multiply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptw_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [ptw_pkg::DVD_W-1:0] i_dividend,
    output logic                      o_done,
    output logic [ptw_pkg::QUO_W-1:0] o_quotient
);
    import ptw_pkg::*;

    logic             r_done;
    logic [PRD_W-1:0] r_prod;

    // Flag the product once a start has captured it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else if (i_start) begin
            r_done <= 1'b1;
        end
    end

    // Multiply by the scaled reciprocal of the divisor
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= PRD_W'(i_dividend) * PRD_W'(RCP_SCALE);
        end
    end

    // Drop the scaling bits
    assign o_done     = r_done;
    assign o_quotient = r_prod[PRD_W-1:RCP_SHIFT];

endmodule
